### rtl/assert_macros.svh
// Shared assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define CHK_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mf2d_pkg.sv
package mf2d_pkg;

  localparam int PIX_W   = 8;
  localparam int CW_W    = 11;  // image_width register
  localparam int CH_W    = 13;  // image_height register
  localparam int CM_W    = 3;   // mask_size register
  localparam int CFG_W   = 13;
  localparam int IDX_W   = 2;
  localparam int MAX_LINES = 4096;
  localparam int ROW_W   = 13;  // in_row may reach the height itself

  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_MASK   = 2'd2;

  localparam logic [CW_W-1:0] RST_WIDTH  = 11'd640;
  localparam logic [CH_W-1:0] RST_HEIGHT = 13'd480;
  localparam logic [CM_W-1:0] RST_MASK   = 3'd3;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             drain;
  } pix_t;

  typedef struct packed {
    logic [PIX_W-1:0] median;
    logic             frame_last;
  } res_t;

  // broadcast to every sort cell
  typedef struct packed {
    logic             clear;
    logic             load;
    logic [PIX_W-1:0] value;
  } cell_ctl_t;

endpackage

### rtl/mf2d_cell.sv
module mf2d_cell (
  input  logic                       clk,
  input  mf2d_pkg::cell_ctl_t        ctl,
  input  logic [mf2d_pkg::PIX_W-1:0] left,
  output logic [mf2d_pkg::PIX_W-1:0] q
);

  logic [mf2d_pkg::PIX_W-1:0] q_next;

  // ascending insertion: larger neighbor shifts in, else keep min
  always_comb begin
    if (ctl.clear) begin
      q_next = '1;
    end else if (ctl.load) begin
      if (left > ctl.value) begin
        q_next = left;
      end else if (ctl.value < q) begin
        q_next = ctl.value;
      end else begin
        q_next = q;
      end
    end else begin
      q_next = q;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

### rtl/mf2d_linebuf.sv
module mf2d_linebuf #(
  parameter int AW = 13
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [mf2d_pkg::PIX_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [mf2d_pkg::PIX_W-1:0] rdata
);

  logic [mf2d_pkg::PIX_W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/median_filter_2d_zero_border.sv
// Each accepted item clears the sort chain and is checked for a ready window; if
//   none, it returns to idle. Else the window goes through the single line-store
//   read port, one read per in-bounds element (zero for border ones), settles, and
//   the median is registered once the output is free. New items wait for idle.
// Reset (rst, synchronous): counters zero, registers 640 / 480 / 3, output empty.
// The line store is not cleared; zero border is generated, never stored.
module median_filter_2d_zero_border #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_MASK  = 7
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pix_valid,
  output logic                            pix_stall,
  input  mf2d_pkg::pix_t                  pix,
  output logic                            res_valid,
  input  logic                            res_stall,
  output mf2d_pkg::res_t                  res,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mf2d_pkg::IDX_W-1:0]      cfg_index,
  input  logic [mf2d_pkg::CFG_W-1:0]      cfg_data
);

  localparam int CB  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int RB  = $clog2(MAX_MASK + 1);
  localparam int MB  = $clog2(MAX_MASK + 1);
  localparam int MSW = (MB > 3) ? MB : 3;
  localparam int WIN = MAX_MASK * MAX_MASK;
  localparam int IB  = $clog2(WIN);
  localparam int AW  = RB + CB;
  localparam int RS  = mf2d_pkg::ROW_W + 1;
  localparam int CS  = WW + 2;
  localparam int PW  = mf2d_pkg::PIX_W;
  localparam int HW  = mf2d_pkg::CH_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_GATHER = 5'b00100,
    S_SETTLE = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [mf2d_pkg::CW_W-1:0] width_reg;
  logic [HW-1:0]             height_reg;
  logic [mf2d_pkg::CM_W-1:0] mask_reg;

  logic [mf2d_pkg::ROW_W-1:0]   in_row;
  logic [CB-1:0]                in_col;
  logic [mf2d_pkg::ROW_W-2:0]   out_row;
  logic [CB-1:0]                out_col;
  logic [MB-1:0]                gi, gj;
  logic                         load_d, inb_d;
  logic [PW-1:0]                rd_data;

  // effective configuration
  logic [13:0]    w_wide;
  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  logic [MSW-1:0] m_clamp;
  logic [MB-1:0]  ms, h2;
  logic [2*MB-1:0] sq;
  logic [IB-1:0]  rank;

  always_comb begin
    w_wide = 14'(width_reg);
    if (w_wide == 14'd0) begin
      w_wide = 14'd1;
    end else if (w_wide > 14'(MAX_WIDTH)) begin
      w_wide = 14'(MAX_WIDTH);
    end
    w_eff = WW'(w_wide);

    if (height_reg == '0) begin
      h_eff = HW'(1);
    end else if (height_reg > HW'(mf2d_pkg::MAX_LINES)) begin
      h_eff = HW'(mf2d_pkg::MAX_LINES);
    end else begin
      h_eff = height_reg;
    end

    m_clamp = MSW'(mask_reg);
    if (m_clamp > MSW'(MAX_MASK)) begin
      m_clamp = MSW'(MAX_MASK);
    end
    if (m_clamp == '0) begin
      m_clamp = MSW'(1);
    end
    if (!m_clamp[0]) begin
      m_clamp = m_clamp - MSW'(1);
    end
    ms   = MB'(m_clamp);
    h2   = ms >> 1;
    sq   = (2*MB)'(ms) * (2*MB)'(ms);
    rank = IB'(sq >> 1);
  end

  // handshakes
  logic pix_acc, res_acc, cfg_acc;
  assign pix_stall = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign pix_acc   = pix_valid && !pix_stall;
  assign res_acc   = res_valid && !res_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;

  logic cfg_hit;
  assign cfg_hit = cfg_acc && (cfg_index == mf2d_pkg::REG_WIDTH ||
                               cfg_index == mf2d_pkg::REG_HEIGHT ||
                               cfg_index == mf2d_pkg::REG_MASK);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= mf2d_pkg::RST_WIDTH;
      height_reg <= mf2d_pkg::RST_HEIGHT;
      mask_reg   <= mf2d_pkg::RST_MASK;
    end else if (cfg_acc) begin
      unique case (cfg_index)
        mf2d_pkg::REG_WIDTH:  width_reg  <= mf2d_pkg::CW_W'(cfg_data);
        mf2d_pkg::REG_HEIGHT: height_reg <= cfg_data;
        mf2d_pkg::REG_MASK:   mask_reg   <= mf2d_pkg::CM_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // line store write on accepted non-drain pixel inside the frame height
  logic store_px;
  assign store_px = pix_acc && !pix.drain && (in_row < mf2d_pkg::ROW_W'(h_eff));

  // output readiness
  logic [mf2d_pkg::ROW_W-1:0] nr;
  logic [WW:0]                nc;
  logic                       ready;
  always_comb begin
    nr = mf2d_pkg::ROW_W'(out_row) + mf2d_pkg::ROW_W'(h2);
    if (nr > mf2d_pkg::ROW_W'(h_eff) - 1'b1) begin
      nr = mf2d_pkg::ROW_W'(h_eff) - 1'b1;
    end
    nc = (WW+1)'(out_col) + (WW+1)'(h2);
    if (nc > (WW+1)'(w_eff) - 1'b1) begin
      nc = (WW+1)'(w_eff) - 1'b1;
    end
    ready = (in_row >= mf2d_pkg::ROW_W'(h_eff)) || (in_row > nr) ||
            ((in_row == nr) && ((WW+1)'(in_col) > nc));
  end

  // window coordinate of the current read
  logic signed [RS-1:0] rr;
  logic signed [CS-1:0] cc;
  logic                 inb;
  logic                 last_rd;
  always_comb begin
    rr  = RS'(out_row) + RS'(gi) - RS'(h2);
    cc  = CS'(out_col) + CS'(gj) - CS'(h2);
    inb = !rr[RS-1] && (rr < RS'(h_eff)) && !cc[CS-1] && (cc < CS'(w_eff));
    last_rd = (gi == ms - 1'b1) && (gj == ms - 1'b1);
  end

  logic rd_en;
  assign rd_en = (state == S_GATHER);

  mf2d_linebuf #(.AW(AW)) u_linebuf (
    .clk   (clk),
    .we    (store_px),
    .waddr ({in_row[RB-1:0], in_col}),
    .wdata (pix.pixel),
    .re    (rd_en && inb),
    .raddr ({rr[RB-1:0], cc[CB-1:0]}),
    .rdata (rd_data)
  );

  // sort chain
  mf2d_pkg::cell_ctl_t ctl;
  logic [PW-1:0] cell_q [WIN];

  assign ctl.clear = (state == S_CHECK);
  assign ctl.load  = load_d;
  assign ctl.value = inb_d ? rd_data : '0;

  for (genvar k = 0; k < WIN; k++) begin : g_cell
    mf2d_cell u_cell (
      .clk  (clk),
      .ctl  (ctl),
      .left ((k == 0) ? '0 : cell_q[(k == 0) ? 0 : k-1]),
      .q    (cell_q[k])
    );
  end

  logic frame_end;
  assign frame_end = (out_row == (mf2d_pkg::ROW_W-1)'(h_eff - 1'b1)) &&
                     ((WW)'(out_col) == w_eff - 1'b1);

  logic res_free;
  assign res_free = !res_valid || !res_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (pix_acc) state_next = S_CHECK;
      S_CHECK:  state_next = ready ? S_GATHER : S_IDLE;
      S_GATHER: if (last_rd) state_next = S_SETTLE;
      S_SETTLE: state_next = S_RESULT;
      S_RESULT: if (res_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
      gi      <= '0;
      gj      <= '0;
      load_d  <= 1'b0;
      inb_d   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state  <= state_next;
      load_d <= rd_en;
      inb_d  <= inb;

      if (res_acc) begin
        res_valid <= 1'b0;
      end

      if (cfg_hit) begin
        in_row  <= '0;
        in_col  <= '0;
        out_row <= '0;
        out_col <= '0;
      end else if (store_px) begin
        if ((WW)'(in_col) >= w_eff - 1'b1) begin
          in_col <= '0;
          in_row <= in_row + 1'b1;
        end else begin
          in_col <= in_col + 1'b1;
        end
      end

      if (state == S_CHECK) begin
        gi <= '0;
        gj <= '0;
      end else if (state == S_GATHER) begin
        if (gj == ms - 1'b1) begin
          gj <= '0;
          gi <= gi + 1'b1;
        end else begin
          gj <= gj + 1'b1;
        end
      end

      if (state == S_RESULT && res_free) begin
        res_valid <= 1'b1;
        if (frame_end) begin
          in_row  <= '0;
          in_col  <= '0;
          out_row <= '0;
          out_col <= '0;
        end else if ((WW)'(out_col) >= w_eff - 1'b1) begin
          out_col <= '0;
          out_row <= out_row + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESULT && res_free) begin
      res.median     <= cell_q[rank];
      res.frame_last <= frame_end;
    end
  end

endmodule

### rtl/mf2d_checker.sv
`include "assert_macros.svh"

module mf2d_checker (
  input logic           clk,
  input logic           rst,
  input logic           pix_valid,
  input logic           pix_stall,
  input logic           res_valid,
  input logic           res_stall,
  input mf2d_pkg::res_t res,
  input logic           cfg_ready
);

  `CHK_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid, "result dropped while stalled")
  `CHK_NEXT(a_res_stable, clk, rst, res_valid && res_stall, $stable(res), "stalled result changed")
  `CHK_NOW(a_cfg_idle, clk, rst, cfg_ready, !pix_stall, "config open while busy")
  `CHK_NEXT(a_one_at_once, clk, rst, pix_valid && !pix_stall, pix_stall, "second item taken early")

endmodule

bind median_filter_2d_zero_border mf2d_checker u_mf2d_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_valid (pix_valid),
  .pix_stall (pix_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res),
  .cfg_ready (cfg_ready)
);
